// ----- src/sbmq_pkg.sv -----
// ----------------------------------------------------------------------------
// sbmq_pkg
// Shared types, sizes and codes for the shared-buffer multi-queue.
// ----------------------------------------------------------------------------
package sbmq_pkg;

  // Store and queue counts
  localparam int SLOTS   = 64;
  localparam int QUEUES  = 4;

  // Field widths fixed by the item format
  localparam int DATA_W  = 32;
  localparam int QID_W   = 2;
  localparam int ST_W    = 2;

  // Slot index and pointer widths; the pointer holds SLOTS as null
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PTR_W   = $clog2(SLOTS + 1);
  localparam int QIDX_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);

  // Operation codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic                     action;
    logic [QID_W-1:0]         queue_id;
    logic signed [DATA_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [ST_W-1:0]          status;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  // Reset content of a link entry: each slot points at the next one,
  // and the last one points at null
  function automatic logic [PTR_W-1:0] link_reset(input logic [IDX_W-1:0] idx);
    link_reset = PTR_W'(idx) + PTR_W'(1);
  endfunction

endpackage

// ----- src/sbmq_ram.sv -----
// ----------------------------------------------------------------------------
// sbmq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sbmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, read one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/sbmq_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbmq_ctrl
// Two-state sequencer: take a request, then commit it in the next cycle.
// ----------------------------------------------------------------------------
module sbmq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output sbmq_pkg::ctrl_cmd_t  cmd,
  output logic                 out_valid
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_COMMIT = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;

  // Decode commands
  always_comb begin
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    state_nxt  = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance state and raise the result strobe after each commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.commit;
    end
  end

  assign busy      = (state_r == ST_COMMIT);
  assign out_valid = out_valid_r;

endmodule

// ----- src/sbmq_dpath.sv -----
// ----------------------------------------------------------------------------
// sbmq_dpath
// Pointer registers, link and data stores, and the result register.
// ----------------------------------------------------------------------------
module sbmq_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sbmq_pkg::ctrl_cmd_t  cmd,
  input  sbmq_pkg::in_item_t   in_item,
  output sbmq_pkg::out_item_t  out_item
);

  localparam int IDX_W  = sbmq_pkg::IDX_W;
  localparam int PTR_W  = sbmq_pkg::PTR_W;
  localparam int QIDX_W = sbmq_pkg::QIDX_W;
  localparam int DATA_W = sbmq_pkg::DATA_W;
  localparam int SLOTS  = sbmq_pkg::SLOTS;
  localparam int QUEUES = sbmq_pkg::QUEUES;

  // Pointer state
  logic [PTR_W-1:0] free_head_r, free_head_nxt;
  logic [PTR_W-1:0] head_r [QUEUES];
  logic [PTR_W-1:0] tail_r [QUEUES];
  logic [SLOTS-1:0] link_vld_r;

  // Request held from accept to commit
  logic              op_r;
  logic [QIDX_W-1:0] qidx_r;
  logic [IDX_W-1:0]  slot_r;
  logic              fail_r;
  logic              q_empty_r;
  logic              rd_vld_r;

  sbmq_pkg::out_item_t out_r, out_nxt;

  // Accept-cycle decode
  logic              acc_q_ok;
  logic [QIDX_W-1:0] acc_qidx;
  logic [PTR_W-1:0]  acc_head;
  logic [PTR_W-1:0]  acc_tail;
  logic [PTR_W-1:0]  acc_slot;
  logic              acc_empty;
  logic              acc_fail;

  // Store ports
  logic              link_we;
  logic [IDX_W-1:0]  link_waddr;
  logic [PTR_W-1:0]  link_wdata;
  logic [IDX_W-1:0]  rd_addr;
  logic [PTR_W-1:0]  link_rdata;
  logic              data_we;
  logic [DATA_W-1:0] data_rdata;
  logic [PTR_W-1:0]  link_val;

  // Look up the addressed queue and pick the slot at hand
  always_comb begin
    acc_q_ok  = (32'(in_item.queue_id) < QUEUES);
    acc_qidx  = QIDX_W'(in_item.queue_id);
    acc_head  = head_r[acc_qidx];
    acc_tail  = tail_r[acc_qidx];
    acc_empty = (acc_head == sbmq_pkg::NIL);
    if (in_item.action == sbmq_pkg::ACT_PUSH) begin
      acc_slot = free_head_r;
      acc_fail = !acc_q_ok || (free_head_r == sbmq_pkg::NIL);
    end else begin
      acc_slot = acc_head;
      acc_fail = !acc_q_ok || acc_empty;
    end
    rd_addr = acc_slot[IDX_W-1:0];
    data_we = cmd.accept && (in_item.action == sbmq_pkg::ACT_PUSH) && !acc_fail;
  end

  // Link of the slot read at accept; an entry never written holds its reset link
  assign link_val = rd_vld_r ? link_rdata : sbmq_pkg::link_reset(slot_r);

  // Share the link write port: tail link at accept, slot link at commit
  always_comb begin
    link_we    = 1'b0;
    link_waddr = slot_r;
    link_wdata = sbmq_pkg::NIL;
    if (cmd.accept && (in_item.action == sbmq_pkg::ACT_PUSH) && !acc_fail && !acc_empty) begin
      link_we    = 1'b1;
      link_waddr = acc_tail[IDX_W-1:0];
      link_wdata = free_head_r;
    end else if (cmd.commit && !fail_r) begin
      link_we    = 1'b1;
      link_waddr = slot_r;
      link_wdata = (op_r == sbmq_pkg::ACT_PUSH) ? sbmq_pkg::NIL : free_head_r;
    end
  end

  // Free head and result at commit
  always_comb begin
    free_head_nxt     = free_head_r;
    out_nxt.data_out  = '0;
    out_nxt.status    = sbmq_pkg::ST_OK;
    if (fail_r) begin
      out_nxt.status = (op_r == sbmq_pkg::ACT_PUSH) ? sbmq_pkg::ST_OVERFLOW
                                                     : sbmq_pkg::ST_EMPTY;
    end else if (op_r == sbmq_pkg::ACT_PUSH) begin
      free_head_nxt = link_val;
    end else begin
      free_head_nxt    = PTR_W'(slot_r);
      out_nxt.data_out = data_rdata;
    end
  end

  sbmq_ram #(
    .WIDTH (PTR_W),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  sbmq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOTS)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (rd_addr),
    .wdata (in_item.data_in),
    .raddr (rd_addr),
    .rdata (data_rdata)
  );

  // Hold the request across the read cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_item.action;
      qidx_r    <= acc_qidx;
      slot_r    <= acc_slot[IDX_W-1:0];
      fail_r    <= acc_fail;
      q_empty_r <= acc_empty;
      rd_vld_r  <= link_vld_r[rd_addr];
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  // Update pointers and link valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      link_vld_r  <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        head_r[i] <= sbmq_pkg::NIL;
        tail_r[i] <= sbmq_pkg::NIL;
      end
    end else begin
      if (link_we) begin
        link_vld_r[link_waddr] <= 1'b1;
      end
      if (cmd.commit) begin
        free_head_r <= free_head_nxt;
      end
      if (cmd.commit && !fail_r) begin
        if (op_r == sbmq_pkg::ACT_PUSH) begin
          if (q_empty_r) begin
            head_r[qidx_r] <= PTR_W'(slot_r);
          end
          tail_r[qidx_r] <= PTR_W'(slot_r);
        end else begin
          head_r[qidx_r] <= link_val;
          if (link_val == sbmq_pkg::NIL) begin
            tail_r[qidx_r] <= sbmq_pkg::NIL;
          end
        end
      end
    end
  end

  assign out_item = out_r;

endmodule

// ----- src/shared_buffer_multi_queue.sv -----
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue
// Several FIFO queues kept as linked lists in one shared slot store.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown on out_item for a single cycle with out_valid
// high; the receiver cannot stall it, so it must take the beat when it comes.
// An item has an accept cycle and a commit cycle: the accept cycle reads the
// slot's link entry from the registered-read link RAM, and the following
// cycle writes the pointers and the link back. busy is high in the commit
// cycle only; the result strobe comes in the cycle after it, while the next
// request may already be taken. Link reset values come from per-slot valid
// bits, so the block is ready right after reset with no clearing pass.
module shared_buffer_multi_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  sbmq_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output sbmq_pkg::out_item_t  out_item
);

  sbmq_pkg::ctrl_cmd_t cmd;

  sbmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  sbmq_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

// ----- src/sbmq_chk.sv -----
// ----------------------------------------------------------------------------
// sbmq_chk
// Port-level checks on request and result timing and result content.
// ----------------------------------------------------------------------------
module sbmq_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input sbmq_pkg::out_item_t  out_item
);

  // An accepted request makes busy high in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // Busy ends with exactly one result beat
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("busy cycle not followed by a result beat");

  // A result beat follows only a busy cycle
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a preceding request");

  // Failed requests return a zero word and a known status
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != sbmq_pkg::ST_OK)) |->
      ((out_item.data_out == '0) &&
       ((out_item.status == sbmq_pkg::ST_OVERFLOW) ||
        (out_item.status == sbmq_pkg::ST_EMPTY))))
    else $error("failed request returned bad data or status");

endmodule

bind shared_buffer_multi_queue sbmq_chk u_sbmq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ----- bench/shared_buffer_multi_queue_tb.sv -----
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_tb
// Self-checking bench for the shared-buffer multi-queue. It drives push and
// pop commands with random idle gaps and keeps its own copy of the linked
// queues and free list. Each result strobe is compared field by field with
// the oldest predicted answer. Directed tests cover empty pops, word extremes,
// FIFO order and a full store; random traffic then shifts between filling,
// draining and balanced phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shared_buffer_multi_queue_tb;
  import sbmq_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 6;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  // Predicted store: slot words, links, per-queue pointers and free list
  logic signed [DATA_W-1:0] slot_word [SLOTS];
  logic [PTR_W-1:0]         slot_next [SLOTS];
  logic [PTR_W-1:0]         q_head [QUEUES];
  logic [PTR_W-1:0]         q_tail [QUEUES];
  logic [PTR_W-1:0]         free_slot;

  out_item_t pending_answers[$];
  int        error_count = 0;
  int        cycle_count = 0;
  bit        gaps_on = 1'b1;

  shared_buffer_multi_queue uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    error_count++;
  endtask

  // Empty queues, whole store on the free list in slot order
  function automatic void clear_queue_model();
    for (int i = 0; i < SLOTS; i++) begin
      slot_word[i] = '0;
      slot_next[i] = PTR_W'(i + 1);
    end
    for (int q = 0; q < QUEUES; q++) begin
      q_head[q] = NIL;
      q_tail[q] = NIL;
    end
    free_slot = '0;
  endfunction

  // Apply one command to the predicted store and return its answer
  function automatic out_item_t predict_queue_op(input in_item_t cmd);
    out_item_t        ans;
    logic [PTR_W-1:0] slot;
    int               q;
    ans.data_out = '0;
    ans.status = ST_OK;
    q = int'(cmd.queue_id);
    if (cmd.action == ACT_PUSH) begin
      slot = free_slot;
      if (q >= QUEUES || slot >= NIL) begin
        ans.status = ST_OVERFLOW;
      end else begin
        free_slot = slot_next[slot];
        if (q_head[q] >= NIL) q_head[q] = slot;
        else slot_next[q_tail[q]] = slot;
        slot_next[slot] = NIL;
        q_tail[q] = slot;
        slot_word[slot] = cmd.data_in;
      end
    end else begin
      slot = (q < QUEUES) ? q_head[q] : NIL;
      if (slot >= NIL) begin
        ans.status = ST_EMPTY;
      end else begin
        q_head[q] = slot_next[slot];
        if (q_head[q] >= NIL) q_tail[q] = NIL;
        slot_next[slot] = free_slot;
        free_slot = slot;
        ans.data_out = slot_word[slot];
      end
    end
    return ans;
  endfunction

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result beats", 0, 1);
      end else begin
        want = pending_answers.pop_front();
        if (out_item.data_out !== want.data_out)
          report_mismatch("data_out", want.data_out, out_item.data_out);
        if (out_item.status !== want.status)
          report_mismatch("status", want.status, out_item.status);
      end
    end
  end

  // Hold the command until the block takes it; start stays high afterwards
  task automatic send_cmd(input logic act, input int q, input logic [DATA_W-1:0] word);
    in_item_t cmd;
    cmd.action = act;
    cmd.queue_id = QID_W'(q);
    cmd.data_in = word;
    start <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy);
    pending_answers.push_back(predict_queue_op(cmd));
  endtask

  // Drop start for a random gap: mostly none or short, sometimes long
  task automatic idle_gap();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (!gaps_on || pick < 55) return;
    len = (pick < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    start <= 1'b0;
    repeat (len) @(posedge clk);
  endtask

  task automatic push_word(input int q, input logic [DATA_W-1:0] word);
    send_cmd(ACT_PUSH, q, word);
    idle_gap();
  endtask

  task automatic pop_word(input int q);
    send_cmd(ACT_POP, q, $urandom());
    idle_gap();
  endtask

  // Pause the sender until every pending answer is back
  task automatic wait_all_answered();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pops of empty queues, on every queue
  task automatic test_empty_pops();
    for (int q = 0; q < QUEUES; q++) pop_word(q);
  endtask

  // Word extremes through each queue, FIFO order, refill after emptying
  task automatic test_extremes_and_order();
    logic [DATA_W-1:0] extremes [4];
    extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    for (int q = 0; q < QUEUES; q++) push_word(q, extremes[q]);
    for (int q = QUEUES - 1; q >= 0; q--) pop_word(q);
    push_word(0, 32'h1234_5678);
    push_word(0, 32'hA5A5_5A5A);
    pop_word(0);
    pop_word(0);
    pop_word(0);
    push_word(0, 32'h5A5A_A5A5);
    pop_word(0);
  endtask

  // Fill the whole store, push past full, reuse a freed slot, drain
  task automatic test_full_store();
    for (int i = 0; i < SLOTS; i++) push_word($urandom_range(0, QUEUES - 1), $urandom());
    push_word(0, $urandom());
    push_word(QUEUES - 1, $urandom());
    pop_word($urandom_range(0, QUEUES - 1));
    pop_word($urandom_range(0, QUEUES - 1));
    push_word($urandom_range(0, QUEUES - 1), $urandom());
    push_word($urandom_range(0, QUEUES - 1), $urandom());
    push_word($urandom_range(0, QUEUES - 1), $urandom());
    for (int q = 0; q < QUEUES; q++) begin
      while (q_head[q] != NIL) pop_word(q);
      pop_word(q);
    end
  endtask

  // Random traffic in phases that fill, drain or balance the store
  task automatic test_random_traffic(input int count);
    int push_pct;
    int focus_q;
    for (int i = 0; i < count; i++) begin
      if (i % 120 == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 85;
          1: push_pct = 20;
          2: push_pct = 50;
          default: push_pct = 60;
        endcase
        focus_q = ($urandom_range(0, 3) == 0) ? $urandom_range(0, QUEUES - 1) : -1;
        gaps_on = ($urandom_range(0, 4) != 0);
      end
      if (i == count / 2) wait_all_answered();
      if ($urandom_range(0, 99) < push_pct)
        push_word((focus_q >= 0) ? focus_q : $urandom_range(0, QUEUES - 1), $urandom());
      else
        pop_word((focus_q >= 0) ? focus_q : $urandom_range(0, QUEUES - 1));
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    clear_queue_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_pops();
    test_extremes_and_order();
    test_full_store();
    wait_all_answered();
    test_random_traffic(1000);

    // Let the last results drain
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
